// ===== src/fnvh_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvh_pkg
// Shared constants and types for the chained hash table.
// ----------------------------------------------------------------------------
package fnvh_pkg;
    localparam int BUCKETS = 256;
    localparam int NODES = 1024;
    localparam int KEY_BYTES_MAX = 8;
    localparam int VALUE_BYTES_MAX = 8;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT = 32'd16777619;
    localparam logic [1:0] REG_BUCKETS = 2'd0;
    localparam logic [1:0] REG_KEYB = 2'd1;
    localparam logic [1:0] REG_VALB = 2'd2;
    localparam logic [1:0] REG_CAP = 2'd3;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam int NODE_W = 64 + 64 + 1 + NW;
    localparam int HEAD_W = NW + NW;

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction
endpackage

// ===== src/fnvh_ram.sv =====
// ----------------------------------------------------------------------------
// fnvh_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fnvh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/fnvh_hash.sv =====
// ----------------------------------------------------------------------------
// fnvh_hash
// Byte-serial FNV-1a hash followed by a serial bucket reduction.
// ----------------------------------------------------------------------------
module fnvh_hash import fnvh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_key,
    input  logic [3:0]    i_nbytes,
    input  logic [8:0]    i_bcount,
    output logic          o_done,
    output logic [BW-1:0] o_bucket
);
    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_BYTE = 2'd1;
    localparam logic [1:0] H_MOD = 2'd2;

    logic [1:0] r_st;
    logic [31:0] r_h;
    logic [63:0] r_key;
    logic [3:0] r_left;
    logic [5:0] r_bit;
    logic [16:0] r_rem;
    logic [16:0] r_div;
    logic [31:0] w_x;
    logic [31:0] w_p;
    logic [17:0] w_sh;

    assign w_x = r_h ^ {24'd0, r_key[7:0]};
    assign w_p = w_x * FNV_MULT;
    assign w_sh = {r_rem, r_h[31]};
    assign o_bucket = r_rem[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= H_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= (r_st == H_MOD) && (r_bit == 6'd1);
            unique case (r_st)
                H_IDLE: begin
                    if (i_start) begin
                        r_h <= FNV_BASIS;
                        r_key <= i_key;
                        r_left <= i_nbytes;
                        r_div <= 17'(i_bcount);
                        r_st <= H_BYTE;
                    end
                end
                H_BYTE: begin
                    r_h <= w_p;
                    r_key <= r_key >> 8;
                    r_left <= r_left - 4'd1;
                    if (r_left == 4'd1) begin
                        r_st <= H_MOD;
                        r_bit <= 6'd32;
                        r_rem <= '0;
                    end
                end
                H_MOD: begin
                    r_h <= r_h << 1;
                    if (w_sh >= 18'(r_div)) begin
                        r_rem <= 17'(w_sh - 18'(r_div));
                    end else begin
                        r_rem <= w_sh[16:0];
                    end
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd1) begin
                        r_st <= H_IDLE;
                    end
                end
                default: r_st <= H_IDLE;
            endcase
        end
    end
endmodule

// ===== src/fnv1a_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// fnv1a_chained_hash_table
// Key-value hash table with FNV-1a bucket hashing and chained nodes.
// ----------------------------------------------------------------------------
// A request on the input channel carries mode, key and value_in. Mode zero
// inserts the pair at the tail of its bucket chain; mode one looks up the key.
// Each request yields one result with status, value_out and entry_count.
// A request hashes its key one byte at a time, reduces the hash to a bucket
// in a 32-step serial remainder loop, reads the bucket head, reads the chain
// nodes it needs and then loads the output register. A lookup reads the nodes
// it walks; an insert into an occupied bucket reads and relinks the old tail
// node. The next request is taken only after the result has been delivered;
// the remainder loop and the single node memory port limit the request rate.
// One request is in flight at a time; the input is stalled while it is being
// worked on or while a result waits. The output register holds its result
// while the receiver stalls.
// Reset clears the bucket valid bits and the entry count; no clearing pass
// is needed. Configuration writes should only be issued while idle.
// ----------------------------------------------------------------------------
module fnv1a_chained_hash_table import fnvh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_value_out,
    output logic [10:0] o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_DEC = 3'd3;
    localparam logic [2:0] S_NODE = 3'd4;
    localparam logic [2:0] S_CMP = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] r_st;
    logic [8:0] r_bc;
    logic [3:0] r_kb, r_vb;
    logic [10:0] r_cap;
    logic [BUCKETS-1:0] r_hv;
    logic [CW-1:0] r_cnt;
    logic r_mode;
    logic [63:0] r_key, r_val, r_km, r_vm;
    logic [BW-1:0] r_b;
    logic [NW-1:0] r_cur;
    logic [15:0] r_steps;

    logic [3:0] w_kb, w_vb;
    logic [8:0] w_bc;
    logic w_hdone;
    logic [BW-1:0] w_bucket;
    logic w_hwe, w_nwe;
    logic [BW-1:0] w_haddr;
    logic [HEAD_W-1:0] w_hwd, w_hrd;
    logic [NW-1:0] w_nwa, w_nra;
    logic [NODE_W-1:0] w_nwd, w_nrd;
    logic [NW-1:0] w_head, w_tail;
    logic w_full;

    assign w_kb = (r_kb == 4'd0) ? 4'd1 : (r_kb > 4'(KEY_BYTES_MAX)) ? 4'(KEY_BYTES_MAX) : r_kb;
    assign w_vb = (r_vb == 4'd0) ? 4'd1
                : (r_vb > 4'(VALUE_BYTES_MAX)) ? 4'(VALUE_BYTES_MAX) : r_vb;
    assign w_bc = (r_bc == 9'd0) ? 9'd1 : (32'(r_bc) > BUCKETS) ? 9'(BUCKETS) : r_bc;
    assign o_stall = (r_st != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_head = w_hrd[NW-1:0];
    assign w_tail = w_hrd[2*NW-1:NW];
    assign w_full = (32'(r_cnt) >= 32'(r_cap)) || (32'(r_cnt) >= NODES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc <= 9'd256;
            r_kb <= 4'd8;
            r_vb <= 4'd8;
            r_cap <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BUCKETS: r_bc <= i_cfg_data[8:0];
                REG_KEYB: r_kb <= i_cfg_data[3:0];
                REG_VALB: r_vb <= i_cfg_data[3:0];
                REG_CAP: r_cap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fnvh_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_valid && r_st == S_IDLE),
        .i_key(i_key & byte_mask(w_kb)), .i_nbytes(w_kb), .i_bcount(w_bc),
        .o_done(w_hdone), .o_bucket(w_bucket)
    );

    // Head memory holds {tail, head}; its valid bit lives in r_hv.
    fnvh_ram #(.WIDTH(HEAD_W), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(w_hwe), .i_waddr(w_haddr), .i_wdata(w_hwd),
        .i_raddr(w_haddr), .o_rdata(w_hrd)
    );

    // Node memory holds {next_valid, next, value, key}.
    fnvh_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(w_nwe), .i_waddr(w_nwa), .i_wdata(w_nwd),
        .i_raddr(w_nra), .o_rdata(w_nrd)
    );

    always_comb begin
        w_hwe = 1'b0;
        w_nwe = 1'b0;
        w_haddr = (r_st == S_HASH) ? w_bucket : r_b;
        w_hwd = {r_cnt[NW-1:0], r_hv[r_b] ? w_head : r_cnt[NW-1:0]};
        w_nwa = r_cnt[NW-1:0];
        w_nwd = {1'b0, {NW{1'b0}}, r_val, r_key};
        w_nra = r_cur;
        if (r_st == S_DEC && !r_mode && !w_full) begin
            w_hwe = 1'b1;
            w_nwe = 1'b1;
        end
        if (r_st == S_CMP && !r_mode) begin
            w_nwe = 1'b1;
            w_nwa = r_cur;
            w_nwd = {1'b1, r_cnt[NW-1:0] - NW'(1), w_nrd[127:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_hv <= '0;
            r_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_key <= i_key & byte_mask(w_kb);
                        r_val <= i_value_in & byte_mask(w_vb);
                        r_km <= byte_mask(w_kb);
                        r_vm <= byte_mask(w_vb);
                        r_st <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hdone) begin
                        r_b <= w_bucket;
                        r_st <= S_HEAD;
                    end
                end
                S_HEAD: r_st <= S_DEC;
                S_DEC: begin
                    o_value_out <= '0;
                    r_steps <= '0;
                    if (!r_mode) begin
                        if (w_full) begin
                            o_status <= ST_FULL;
                            r_st <= S_OUT;
                        end else begin
                            o_status <= ST_OK;
                            r_hv[r_b] <= 1'b1;
                            r_cnt <= r_cnt + CW'(1);
                            r_cur <= w_tail;
                            r_st <= r_hv[r_b] ? S_NODE : S_OUT;
                        end
                    end else begin
                        o_status <= ST_MISS;
                        r_cur <= w_head;
                        r_st <= r_hv[r_b] ? S_NODE : S_OUT;
                    end
                end
                S_NODE: r_st <= r_mode ? S_CMP : S_CMP;
                S_CMP: begin
                    if (!r_mode) begin
                        r_st <= S_OUT;
                    end else if (((w_nrd[63:0] ^ r_key) & r_km) == 64'd0) begin
                        o_status <= ST_OK;
                        o_value_out <= w_nrd[127:64] & r_vm;
                        r_st <= S_OUT;
                    end else if (!w_nrd[NODE_W-1] || 32'(r_steps) >= NODES - 1) begin
                        r_st <= S_OUT;
                    end else begin
                        r_cur <= w_nrd[128 +: NW];
                        r_steps <= r_steps + 16'd1;
                        r_st <= S_NODE;
                    end
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_entry_count <= 11'(r_cnt);
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
